FILE: rtl/core/egk_pkg.sv
// Shared types, codes and the increment pattern table of the envelope generator slot.
package egk_pkg;

  localparam int COUNTER_BITS_DEFAULT = 16;
  // Counter bits that the increment logic ever looks at: largest shift plus a 3-bit column.
  localparam int CNT_USE_BITS = 14;

  typedef logic [1:0] seg_t;
  localparam seg_t SEG_ATTACK  = 2'd0;
  localparam seg_t SEG_DECAY1  = 2'd1;
  localparam seg_t SEG_DECAY2  = 2'd2;
  localparam seg_t SEG_RELEASE = 2'd3;

  typedef logic [1:0] koff_mode_t;
  localparam koff_mode_t KOFF_OLD_RATE = 2'd0;
  localparam koff_mode_t KOFF_OLD_STEP = 2'd1;
  localparam koff_mode_t KOFF_RELEASE  = 2'd2;
  localparam koff_mode_t KOFF_NO_STEP  = 2'd3;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_ATTACK_RATE  = 3'd0;
  localparam reg_idx_t REG_DECAY1_RATE  = 3'd1;
  localparam reg_idx_t REG_DECAY2_RATE  = 3'd2;
  localparam reg_idx_t REG_RELEASE_RATE = 3'd3;
  localparam reg_idx_t REG_DECAY_LEVEL  = 3'd4;
  localparam reg_idx_t REG_KEYOFF_MODE  = 3'd5;

  localparam logic [9:0] ATTEN_MAX     = 10'h3FF;
  localparam logic [9:0] ATTEN_KEY_ON  = 10'h280;
  localparam logic [14:0] FULL_SCALE   = 15'd32767;
  localparam logic [4:0] ROW_FASTEST   = 5'd16;
  localparam logic [5:0] RATE_ROW_BASE = 6'd44;

  typedef struct packed {
    logic        opcode;
    logic        key_off;
    logic        eg_clock;
    logic [15:0] env_counter;
  } sample_t;

  typedef struct packed {
    logic [9:0]  attenuation;
    logic [1:0]  segment;
    logic        silenced;
    logic [18:0] mix_level;
  } result_t;

  typedef struct packed {
    reg_idx_t    index;
    logic [5:0]  value;
  } cfg_wr_t;

  typedef struct packed {
    logic [5:0]  attack_rate;
    logic [5:0]  decay1_rate;
    logic [5:0]  decay2_rate;
    logic [5:0]  release_rate;
    logic [4:0]  decay_level;
    koff_mode_t  keyoff_mode;
  } cfg_t;

  localparam logic [3:0] INC_PATTERN [0:16][0:7] = '{
    '{4'd0, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1},
    '{4'd0, 4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1},
    '{4'd0, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd1, 4'd1},
    '{4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd2},
    '{4'd1, 4'd2, 4'd2, 4'd2, 4'd1, 4'd2, 4'd2, 4'd2},
    '{4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2},
    '{4'd2, 4'd4, 4'd2, 4'd2, 4'd2, 4'd4, 4'd2, 4'd2},
    '{4'd2, 4'd4, 4'd2, 4'd4, 4'd2, 4'd4, 4'd2, 4'd4},
    '{4'd2, 4'd4, 4'd4, 4'd4, 4'd2, 4'd4, 4'd4, 4'd4},
    '{4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4},
    '{4'd4, 4'd8, 4'd4, 4'd4, 4'd4, 4'd8, 4'd4, 4'd4},
    '{4'd4, 4'd8, 4'd4, 4'd8, 4'd4, 4'd8, 4'd4, 4'd8},
    '{4'd4, 4'd8, 4'd8, 4'd8, 4'd4, 4'd8, 4'd8, 4'd8},
    '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8}
  };

endpackage

FILE: rtl/core/egk_chan_if.sv
// Valid/ready channel carrying one word of a payload type.
interface egk_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/egk_cfg.sv
// Configuration registers of the envelope generator slot.
module egk_cfg
  import egk_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  cfg_wr_t wr,
  output cfg_t    regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr_en) begin
      case (wr.index)
        REG_ATTACK_RATE:  regs.attack_rate  <= wr.value;
        REG_DECAY1_RATE:  regs.decay1_rate  <= wr.value;
        REG_DECAY2_RATE:  regs.decay2_rate  <= wr.value;
        REG_RELEASE_RATE: regs.release_rate <= wr.value;
        REG_DECAY_LEVEL:  regs.decay_level  <= wr.value[4:0];
        REG_KEYOFF_MODE:  regs.keyoff_mode  <= wr.value[1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/egk_rate.sv
// Increment lookup from a segment rate and the global envelope counter.
module egk_rate
  import egk_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
  input  logic [5:0]  rate,
  input  logic [15:0] env_counter,
  output logic [3:0]  inc
);

  localparam int ExtW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;

  logic [ExtW-1:0]         cnt_ext;
  logic [COUNTER_BITS-1:0] cnt;
  logic [COUNTER_BITS-1:0] cnt_m1;
  logic [CNT_USE_BITS-1:0] low;
  logic [CNT_USE_BITS-1:0] mask;
  logic [3:0]              sh;
  logic [2:0]              col_slow;
  logic [4:0]              row;
  logic [2:0]              col;

  assign cnt_ext  = ExtW'(env_counter);
  assign cnt      = cnt_ext[COUNTER_BITS-1:0];
  assign cnt_m1   = cnt - COUNTER_BITS'(1);
  assign low      = cnt_m1[CNT_USE_BITS-1:0];
  assign sh       = 4'd11 - rate[5:2];
  assign mask     = (CNT_USE_BITS'(1) << sh) - CNT_USE_BITS'(1);
  assign col_slow = 3'(low >> sh);

  always_comb begin
    row = ROW_FASTEST;
    col = cnt[2:0];
    inc = '0;
    if (rate == 6'd0) begin
      inc = '0;
    end else if (rate < 6'd48) begin
      // Slow rates step only when the shifted-out bits of the counter minus one are all zero.
      row = {3'b000, rate[1:0]};
      col = col_slow;
      inc = ((low & mask) == '0) ? INC_PATTERN[row][col] : 4'd0;
    end else begin
      row = (rate >= 6'd60) ? ROW_FASTEST : 5'(rate - RATE_ROW_BASE);
      inc = INC_PATTERN[row][col];
    end
  end

endmodule

FILE: rtl/core/egk_slot.sv
// Envelope state registers and the single-pass next-state and level logic.
module egk_slot
  import egk_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    go,
  input  sample_t item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [9:0]  atten;
  seg_t        segment;
  logic        silenced;
  seg_t        prior;

  logic [9:0]  atten_next;
  seg_t        segment_next;
  logic        silenced_next;
  seg_t        prior_next;

  seg_t        seg_ko;
  seg_t        rate_seg;
  logic [5:0]  rate;
  logic [3:0]  inc;
  logic        koff;
  logic        clocked;
  logic        was_d1;
  logic        attack_step;
  logic [13:0] dec_prod;
  logic [9:0]  dec;
  logic [10:0] sum;
  logic [21:0] level_prod;
  logic [21:0] level_shift;

  assign koff     = item.key_off;
  assign seg_ko   = koff ? SEG_RELEASE : segment;
  assign rate_seg = (koff && (cfg.keyoff_mode == KOFF_OLD_RATE ||
                              cfg.keyoff_mode == KOFF_OLD_STEP)) ? segment : seg_ko;

  always_comb begin
    case (rate_seg)
      SEG_ATTACK: rate = cfg.attack_rate;
      SEG_DECAY1: rate = cfg.decay1_rate;
      SEG_DECAY2: rate = cfg.decay2_rate;
      default:    rate = cfg.release_rate;
    endcase
  end

  egk_rate #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_rate (
    .rate       (rate),
    .env_counter(item.env_counter),
    .inc        (inc)
  );

  assign clocked  = item.eg_clock && !silenced &&
                    !(koff && cfg.keyoff_mode == KOFF_NO_STEP);
  assign was_d1   = (seg_ko == SEG_DECAY1);
  // A key-off with the old-step mode repeats the attack formula if attack was running.
  assign attack_step = (seg_ko == SEG_ATTACK) ||
                       (koff && cfg.keyoff_mode == KOFF_OLD_STEP && segment == SEG_ATTACK);
  assign dec_prod = 14'(({4'b0, atten} + 14'd1) * {10'b0, inc} + 14'd15);
  assign dec      = dec_prod[13:4];
  assign sum      = {1'b0, atten} + {7'b0, inc};

  always_comb begin
    atten_next    = atten;
    segment_next  = segment;
    silenced_next = silenced;
    prior_next    = prior;
    if (item.opcode) begin
      atten_next    = (&cfg.attack_rate) ? 10'd0 : ATTEN_KEY_ON;
      segment_next  = SEG_ATTACK;
      silenced_next = 1'b0;
      prior_next    = SEG_ATTACK;
    end else begin
      segment_next = seg_ko;
      if (koff) begin
        prior_next = segment;
      end
      if (clocked) begin
        if (inc != 4'd0) begin
          if (attack_step) begin
            if (dec >= atten) begin
              atten_next = 10'd0;
              if (seg_ko == SEG_ATTACK) begin
                segment_next = SEG_DECAY1;
              end
            end else begin
              atten_next = atten - dec;
            end
          end else if (sum[10]) begin
            atten_next    = ATTEN_MAX;
            silenced_next = 1'b1;
          end else begin
            atten_next = sum[9:0];
          end
        end
        if (was_d1 && !silenced_next && atten_next[9:5] == cfg.decay_level) begin
          segment_next = SEG_DECAY2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      atten    <= ATTEN_MAX;
      segment  <= SEG_RELEASE;
      silenced <= 1'b1;
      prior    <= SEG_ATTACK;
    end else if (go) begin
      atten    <= atten_next;
      segment  <= segment_next;
      silenced <= silenced_next;
      prior    <= prior_next;
    end
  end

  // Level = 16 * ((32767 * (127 - low six bits)) >> (7 + upper four bits)).
  assign level_prod  = 22'(FULL_SCALE) * 22'({1'b1, ~atten_next[5:0]});
  assign level_shift = level_prod >> ({1'b0, atten_next[9:6]} + 5'd7);

  assign res.attenuation = atten_next;
  assign res.segment     = segment_next;
  assign res.silenced    = silenced_next;
  assign res.mix_level   = silenced_next ? 19'd0 : {level_shift[14:0], 4'b0000};

endmodule

FILE: rtl/core/envelope_generator_keyoff_core.sv
// Top level of one envelope generator slot with selectable key-off stepping.
//
//   Port      Direction  Word       Role
//   sample    sink       sample_t   key-on or sample tick with counter
//   result    source     result_t   attenuation, segment, silenced, level
//   cfg       sink       cfg_wr_t   register index and write data
//
// One word is taken into the input register when it is empty or its word advances; its
// result is loaded into the output register, with result valid, when the word advances.
// The envelope state feeds back into the next word, which sets the rate at one word per
// cycle while the result is not stalled. Reset is synchronous and leaves the slot silent.
// A stalled result holds the output register; the input register then accepts a word
// only while it is empty. cfg is always ready.
module envelope_generator_keyoff_core
  import egk_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  egk_chan_if.sink     sample,
  egk_chan_if.source   result,
  egk_chan_if.sink     cfg
);

  sample_t in_word;
  logic    in_valid;
  result_t out_word;
  logic    out_valid;
  result_t res_next;
  cfg_t    cfg_regs;
  logic    advance;

  assign advance      = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || advance;
  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign result.data  = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_word <= sample.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= res_next;
    end
  end

  egk_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .wr_en(cfg.valid),
    .wr   (cfg.data),
    .regs (cfg_regs)
  );

  egk_slot #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_slot (
    .clk (clk),
    .rst (rst),
    .go  (advance),
    .item(in_word),
    .cfg (cfg_regs),
    .res (res_next)
  );

endmodule

FILE: rtl/core/egk_checker.sv
// Port-level checks on the result channel of the envelope generator slot.
module egk_checker
  import egk_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    res_valid,
  input logic    res_ready,
  input result_t res_data
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result word changed while stalled");

  a_silent_max: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.silenced |->
      res_data.attenuation == ATTEN_MAX && res_data.mix_level == 19'd0)
    else $error("silenced slot without full attenuation and zero level");

  a_attack_live: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.segment == SEG_ATTACK |-> !res_data.silenced)
    else $error("slot silenced during attack");

  a_level_grain: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.mix_level[3:0] == 4'd0)
    else $error("level not a multiple of sixteen");

endmodule

bind envelope_generator_keyoff_core egk_checker u_egk_checker (
  .clk      (clk),
  .rst      (rst),
  .res_valid(result.valid),
  .res_ready(result.ready),
  .res_data (result.data)
);
